// ===== src/pds_pkg.sv =====
`timescale 1ns / 1ps
package pds_pkg;
    localparam int BANK_BYTES = 65536;
    localparam int BANK_AW = $clog2(BANK_BYTES);
    localparam int LEN_W = BANK_AW + 1;

    localparam logic [2:0] OP_SET_CURSOR = 3'd0;
    localparam logic [2:0] OP_UPLOAD     = 3'd1;
    localparam logic [2:0] OP_START      = 3'd2;
    localparam logic [2:0] OP_SYNC       = 3'd3;
    localparam logic [2:0] OP_STOP       = 3'd4;
    localparam logic [2:0] OP_SEEK_HIGH  = 3'd5;
    localparam logic [2:0] OP_SEED_RATE  = 3'd6;
    localparam logic [2:0] OP_TICK       = 3'd7;

    localparam logic [0:0] CFG_SEED_RATE = 1'b0;
    localparam logic [0:0] CFG_SYNC_ADV  = 1'b1;

    localparam logic [21:0] SEED_RATE_RESET = 22'd17224;
    localparam logic [5:0]  SYNC_ADV_RESET  = 6'd32;
    localparam logic [31:0] ECHO_TICKS = 32'd12;
    localparam logic [7:0]  EMPTY_SAMPLE = 8'h80;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] high_byte;
        logic [7:0] low_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  dac_sample;
        logic [23:0] sample_index;
    } t_out;
endpackage

// ===== src/pds_ram.sv =====
`timescale 1ns / 1ps
module pds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/pds_queue.sv =====
`timescale 1ns / 1ps
module pds_queue import pds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_in  o_data
);
    // two-entry fifo
    t_in  r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> r_cnt == 2'd2) else $error("queue lost entry");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !push) |=> !o_valid) else $error("queue invented entry");
endmodule

// ===== src/pds_divider.sv =====
`timescale 1ns / 1ps
module pds_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [21:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [21:0] o_quo
);
    // restoring divide, one quotient bit per cycle
    logic [21:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [32:0] trial;
    logic [32:0] sh;
    assign sh = {r_rem[31:0], r_q[21]};
    assign trial = sh - {1'b0, r_den};
    assign o_quo = r_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= 5'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= i_num;
                r_rem <= 33'd0;
                r_den <= i_den;
                r_cnt <= 5'd21;
            end else if (r_busy) begin
                if (!trial[32]) begin
                    r_rem <= trial;
                    r_q <= {r_q[20:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q <= {r_q[20:0], 1'b0};
                end
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end
endmodule

// ===== src/pds_engine.sv =====
`timescale 1ns / 1ps
module pds_engine import pds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [21:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PHASE = 3'd4;

    logic [2:0]  r_state;
    logic [21:0] r_seed;
    logic [5:0]  r_adv;
    logic [17:0] r_cursor;
    logic [LEN_W-1:0] r_len;
    logic [7:0]  r_seek;
    logic        r_play;
    logic [39:0] r_pos;
    logic [23:0] r_last;
    logic [23:0] r_ckpt;
    logic [21:0] r_rate;
    logic [31:0] r_tick;
    logic [31:0] r_ctick;
    logic [23:0] r_eidx;
    logic        r_ovalid;

    logic [15:0] arg;
    logic [17:0] coarse;
    logic [31:0] dt;
    assign arg = {i_data.high_byte, i_data.low_byte};
    assign coarse = {arg, 2'b00};
    assign dt = r_tick - r_ctick;

    // tick arithmetic
    logic [39:0] limit, adv_pos, tick_pos;
    logic [23:0] want;
    assign limit = {r_ckpt, 16'd0};
    assign adv_pos = r_pos + {18'd0, r_rate};
    always_comb begin
        tick_pos = r_pos;
        if (r_pos < limit) tick_pos = (adv_pos > limit) ? limit : adv_pos;
    end
    assign want = tick_pos[39:16];

    logic [23:0] start_pos;
    assign start_pos = {r_seek, arg};

    // bank read address selection
    logic        in_range;
    logic [BANK_AW-1:0] raddr;
    logic        empty;
    assign in_range = ({8'd0, r_eidx} < {{(32-LEN_W){1'b0}}, r_len})
        && ({8'd0, r_eidx} < 32'(BANK_BYTES));
    assign empty = (r_len == '0);
    logic [LEN_W-1:0] len_m1;
    assign len_m1 = r_len - 1'b1;
    assign raddr = in_range ? r_eidx[BANK_AW-1:0] : len_m1[BANK_AW-1:0];

    logic bank_we;
    logic [7:0] rdata;
    assign bank_we = (r_state == S_IDLE) && i_valid && o_ready
        && i_data.operation == OP_UPLOAD && ({14'd0, r_cursor} < 32'(BANK_BYTES));
    pds_ram #(.WIDTH(8), .DEPTH(BANK_BYTES)) u_bank (
        .i_clk(i_clk), .i_we(bank_we), .i_waddr(r_cursor[BANK_AW-1:0]),
        .i_wdata(i_data.low_byte), .i_raddr(raddr), .o_rdata(rdata)
    );

    // rate divide on sync
    logic        div_start, div_done;
    logic [21:0] quo;
    assign div_start = (r_state == S_IDLE) && i_valid && o_ready
        && i_data.operation == OP_SYNC && r_play && r_rate != 22'd0
        && !(r_play && {6'd0, coarse} == r_ckpt && dt < ECHO_TICKS) && dt != 32'd0;
    pds_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({r_adv, 16'd0}), .i_den(dt), .o_done(div_done), .o_quo(quo)
    );

    logic [22:0] diff;
    logic [22:0] step;
    assign diff = {1'b0, quo} - {1'b0, r_rate};
    assign step = {{2{diff[22]}}, diff[22:2]};

    logic signed [25:0] err;
    assign err = $signed({2'b00, r_ckpt}) - $signed({2'b00, r_pos[39:16]});

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data.dac_sample = empty ? EMPTY_SAMPLE : rdata;
    assign o_data.sample_index = r_eidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seed <= SEED_RATE_RESET;
            r_adv <= SYNC_ADV_RESET;
            r_cursor <= '0;
            r_len <= '0;
            r_seek <= '0;
            r_play <= 1'b0;
            r_pos <= '0;
            r_last <= '0;
            r_ckpt <= '0;
            r_rate <= '0;
            r_tick <= '0;
            r_ctick <= '0;
            r_ovalid <= 1'b0;
            r_eidx <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SEED_RATE) r_seed <= i_cfg_data;
                else r_adv <= i_cfg_data[5:0];
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    case (i_data.operation)
                        OP_SET_CURSOR: begin
                            r_cursor <= coarse;
                            if (coarse == 18'd0) r_len <= '0;
                        end
                        OP_UPLOAD: if (bank_we) begin
                            r_cursor <= r_cursor + 18'd1;
                            if ((r_cursor + 18'd1) > 18'(r_len)) r_len <= LEN_W'(r_cursor + 18'd1);
                        end
                        OP_START: begin
                            r_pos <= {start_pos, 16'd0};
                            r_last <= start_pos;
                            r_ckpt <= start_pos;
                            r_ctick <= r_tick;
                            if (r_rate == 22'd0) r_rate <= r_seed;
                            r_play <= 1'b1;
                            if ({8'd0, start_pos} < {{(32-LEN_W){1'b0}}, r_len}) begin
                                r_eidx <= start_pos;
                                r_state <= S_READ;
                            end
                        end
                        OP_SYNC: if (!(r_play && {6'd0, coarse} == r_ckpt
                                       && dt < ECHO_TICKS)) begin
                            r_ctick <= r_tick;
                            r_ckpt <= {6'd0, coarse};
                            if (!r_play || r_rate == 22'd0) begin
                                r_play <= 1'b1;
                                r_rate <= r_seed;
                                r_pos <= {6'd0, coarse, 16'd0};
                                r_last <= {6'd0, coarse};
                            end else if (dt != 32'd0) begin
                                r_state <= S_DIV;
                            end else begin
                                r_state <= S_PHASE;
                            end
                        end
                        OP_STOP: r_play <= 1'b0;
                        OP_SEEK_HIGH: r_seek <= i_data.low_byte;
                        OP_SEED_RATE: if (arg != 16'd0) r_rate <= {6'd0, arg};
                        default: begin
                            r_tick <= r_tick + 32'd1;
                            if (r_play && r_rate != 22'd0) begin
                                r_pos <= tick_pos;
                                if (want > r_last) begin
                                    r_last <= want;
                                    r_eidx <= want;
                                    r_state <= S_READ;
                                end
                            end
                        end
                    endcase
                end
                S_READ: r_state <= S_WAIT;
                S_WAIT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DIV: if (div_done) begin
                    r_rate <= r_rate + step[21:0];
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    if (err > 26'sd96 || err < -26'sd96) begin
                        r_pos <= {r_ckpt, 16'd0};
                        r_last <= r_ckpt;
                    end else if (err > 26'sd12) begin
                        r_pos <= r_pos + {14'd0, err[12:0] - 13'd12, 13'd0};
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_WAIT)) else $error("read sequence");
endmodule

// ===== src/pcm_dac_checkpoint_streamer.sv =====
`timescale 1ns / 1ps
// channel   direction  payload                              handshake
// in        input      operation, high_byte, low_byte       i_in_valid / o_in_ready
// out       output     dac_sample, sample_index             o_out_valid / i_out_ready
// cfg       input      seed_rate, sync_advance_bytes        i_cfg_we
//
// commands without a result, tracked syncs apart, keep the engine in S_IDLE; a result passes
// through S_READ and S_WAIT after the engine takes its command, and the next one goes in once the handshake clears it
// a tracked sync passes through S_DIV (22-step divider) and S_PHASE, a sync with no elapsed ticks only through S_PHASE
// a 2-entry transaction queue sits in front, so input stalls only when it fills
// reset is synchronous, active low; the bank is not cleared
// the engine waits while a result is pending on the output
module pcm_dac_checkpoint_streamer import pds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [21:0] i_cfg_data
);
    // front queue to engine
    logic q_valid, q_ready;
    t_in  q_data;

    pds_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_data(i_in_data),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    pds_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(q_valid), .o_ready(q_ready), .i_data(q_data),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_data(o_out_data)
    );
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import pds_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [21:0] i_cfg_data;

    pcm_dac_checkpoint_streamer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predicted streamer state
    logic [7:0]  bank_mem [0:BANK_BYTES-1];
    logic [17:0] cursor;
    logic [16:0] valid_len;
    logic [7:0]  seek_hi;
    logic        running;
    logic [39:0] position;
    logic [23:0] last_index;
    logic [23:0] anchor_pos;
    logic [21:0] rate;
    logic [31:0] ticks;
    logic [31:0] anchor_tick;
    logic [21:0] seed_cfg;
    logic [5:0]  advance_cfg;

    t_out  sample_queue [$];
    int    fail_count;
    int    cycle_count;
    int    send_idle_pct;
    int    recv_idle_pct;

    localparam int CYCLE_LIMIT = 2000000;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] bank_byte(input logic [23:0] idx);
        logic [16:0] last;
        last = valid_len - 17'd1;
        if (idx < valid_len)
            return bank_mem[idx[15:0]];
        if (valid_len != 0)
            return bank_mem[last[15:0]];
        return EMPTY_SAMPLE;
    endfunction

    task automatic push_sample(input logic [23:0] idx);
        t_out s;
        s.dac_sample = bank_byte(idx);
        s.sample_index = idx;
        sample_queue.push_back(s);
    endtask

    task automatic predict_sync(input logic [17:0] coarse);
        logic [31:0] dt;
        longint inst, diff, stp, err;
        dt = ticks - anchor_tick;
        if (running && {6'd0, coarse} == anchor_pos && dt < ECHO_TICKS)
            return;
        anchor_tick = ticks;
        anchor_pos = {6'd0, coarse};
        if (!running || rate == 0) begin
            // not running or no rate yet: seed and snap
            running = 1'b1;
            rate = seed_cfg;
            position = {6'd0, coarse, 16'd0};
            last_index = {6'd0, coarse};
            return;
        end
        if (dt != 0) begin
            inst = longint'((64'(advance_cfg) << 16) / 64'(dt));
            diff = inst - longint'(rate);
            stp = diff >= 0 ? diff / 4 : -((-diff + 3) / 4);
            rate = 22'(longint'(rate) + stp);
        end
        err = longint'(coarse) - longint'(position[39:16]);
        if (err > 96 || err < -96) begin
            position = {6'd0, coarse, 16'd0};
            last_index = {6'd0, coarse};
        end else if (err > 12) begin
            position = position + (40'(err - 12) << 13);
        end
    endtask

    // model one accepted transaction
    task automatic predict_item(input t_in it);
        logic [15:0] arg;
        logic [23:0] pos;
        logic [39:0] lim;
        arg = {it.high_byte, it.low_byte};
        case (it.operation)
            OP_SET_CURSOR: begin
                cursor = {arg, 2'b00};
                if (cursor == 0) valid_len = '0;
            end
            OP_UPLOAD: begin
                if (cursor < BANK_BYTES) begin
                    bank_mem[cursor[15:0]] = it.low_byte;
                    cursor = cursor + 18'd1;
                    if (cursor > valid_len) valid_len = cursor[16:0];
                end
            end
            OP_START: begin
                pos = {seek_hi, arg};
                position = {pos, 16'd0};
                last_index = pos;
                anchor_pos = pos;
                anchor_tick = ticks;
                if (rate == 0) rate = seed_cfg;
                running = 1'b1;
                if (pos < valid_len) push_sample(pos);
            end
            OP_SYNC:      predict_sync({arg, 2'b00});
            OP_STOP:      running = 1'b0;
            OP_SEEK_HIGH: seek_hi = it.low_byte;
            OP_SEED_RATE: if (arg != 0) rate = {6'd0, arg};
            default: begin
                if (running && rate != 0) begin
                    lim = {anchor_pos, 16'd0};
                    if (position < lim) begin
                        position = position + rate;
                        if (position > lim) position = lim;
                    end
                    if (position[39:16] > last_index) begin
                        last_index = position[39:16];
                        push_sample(last_index);
                    end
                end
                ticks = ticks + 32'd1;
            end
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out exp_s;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sample_queue.size() == 0) begin
                $error("unexpected sample index %0d", o_out_data.sample_index);
                fail_count++;
            end else begin
                exp_s = sample_queue.pop_front();
                if (o_out_data.dac_sample !== exp_s.dac_sample) begin
                    $error("dac_sample exp %0h got %0h", exp_s.dac_sample,
                           o_out_data.dac_sample);
                    fail_count++;
                end
                if (o_out_data.sample_index !== exp_s.sample_index) begin
                    $error("sample_index exp %0h got %0h", exp_s.sample_index,
                           o_out_data.sample_index);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays up after acceptance until the next idle cycle or drain
    task automatic send_item(input logic [2:0] op, input logic [7:0] hi, input logic [7:0] lo);
        t_in it;
        it.operation = op;
        it.high_byte = hi;
        it.low_byte = lo;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(it);
    endtask

    // wait for every result, then let the engine finish queued syncs
    task automatic drain;
        i_in_valid <= 1'b0;
        while (sample_queue.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [21:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SEED_RATE) seed_cfg = val;
        else advance_cfg = val[5:0];
        @(posedge i_clk);
    endtask

    task automatic upload_ramp(input int n);
        send_item(OP_SET_CURSOR, 8'h00, 8'h00);
        for (int k = 0; k < n; k++) send_item(OP_UPLOAD, 8'h00, 8'($urandom));
    endtask

    // extremes, empty bank, every operation, echo, snap, pull
    task automatic test_directed;
        send_item(OP_START, 8'h00, 8'h00);
        send_item(OP_TICK, 8'hFF, 8'hFF);
        send_item(OP_SYNC, 8'h00, 8'h01);
        repeat (3) send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_STOP, 8'h00, 8'h00);
        upload_ramp(12);
        send_item(OP_SEEK_HIGH, 8'h00, 8'hFF);
        send_item(OP_SEEK_HIGH, 8'h00, 8'h00);
        send_item(OP_SEED_RATE, 8'hFF, 8'hFF);
        send_item(OP_START, 8'h00, 8'h02);
        send_item(OP_SYNC, 8'h00, 8'h02);
        send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_SYNC, 8'h00, 8'h02);  // echo, dropped
        send_item(OP_SYNC, 8'h00, 8'h40);  // large error, snap
        send_item(OP_SYNC, 8'h00, 8'h48);  // moderate error, pull
        repeat (4) send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_SEED_RATE, 8'h00, 8'h00);
        send_item(OP_SET_CURSOR, 8'hFF, 8'hFF);
        send_item(OP_UPLOAD, 8'hAA, 8'h55);
        drain();
    endtask

    // well-formed upload / start / tick / sync sessions with noise
    task automatic test_random(input int n_items);
        int sent;
        int len;
        int coarse;
        logic [2:0] op;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(8, 40);
            upload_ramp(len);
            send_item(OP_SEEK_HIGH, 8'h00, ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00);
            send_item(OP_START, 8'h00, 8'($urandom_range(3)));
            sent += len + 4;
            send_item(OP_SEEK_HIGH, 8'h00, 8'h00);
            coarse = 0;
            for (int s = 0; s < 4; s++) begin
                for (int t = 0; t < $urandom_range(2, 14); t++) begin
                    if ($urandom_range(19) == 0) begin
                        // a cursor move only to zero keeps the bank gap-free
                        op = 3'($urandom);
                        if (op == OP_SET_CURSOR)
                            send_item(op, 8'h00, 8'h00);
                        else
                            send_item(op, 8'($urandom), 8'($urandom));
                    end else begin
                        send_item(OP_TICK, 8'($urandom), 8'($urandom));
                    end
                    sent++;
                end
                coarse += $urandom_range(1, 3);
                send_item(OP_SYNC, 8'(coarse >> 8), 8'(coarse));
                sent++;
            end
            if ($urandom_range(3) == 0) begin
                send_item(OP_STOP, 8'h00, 8'h00);
                sent++;
            end
        end
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 13;
        recv_idle_pct = 78;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SEED_RATE;
        i_cfg_data = '0;
        cursor = '0; valid_len = '0; seek_hi = '0; running = 1'b0;
        position = '0; last_index = '0; anchor_pos = '0; rate = '0;
        ticks = '0; anchor_tick = '0;
        seed_cfg = SEED_RATE_RESET;
        advance_cfg = SYNC_ADV_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(210);
        drain();

        // other idle mix and extreme register values
        send_idle_pct = 78;
        recv_idle_pct = 13;
        write_cfg(CFG_SEED_RATE, 22'd2097152);
        write_cfg(CFG_SYNC_ADV, 22'd1);
        test_random(210);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(CFG_SEED_RATE, 22'd1);
        write_cfg(CFG_SYNC_ADV, 22'd63);
        test_random(115);
        drain();
        write_cfg(CFG_SEED_RATE, 22'h3FFFFF);
        write_cfg(CFG_SYNC_ADV, 22'd32);
        test_random(115);
        drain();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
